// File: sv/fplb_pkg.sv
// Shared constants and types of the flow path load balancer.
package fplb_pkg;

  localparam int unsigned FLOW_ENTRIES = 128;
  localparam int unsigned FLOW_IDX_W   = $clog2(FLOW_ENTRIES);

  localparam int unsigned FLOW_ID_W = 7;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned QLEN_W    = 16;
  localparam int unsigned PATH_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMBALANCE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_FLOW_MIN_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH            = 2'd2;

  localparam logic [QLEN_W-1:0]  IMBALANCE_THRESHOLD_RST = 16'd3;
  localparam logic [BYTES_W-1:0] NEW_FLOW_MIN_BYTES_RST  = 16'd500;
  localparam logic [PATH_W-1:0]  MAX_PATH_RST            = 3'd2;

  localparam logic [SEQ_W-1:0]  FIRST_SEGMENT_SEQ = 32'd1;
  localparam logic [PATH_W-1:0] PATH_ZERO         = 3'd0;

  typedef struct packed {
    logic [FLOW_ID_W-1:0] flow_id;
    logic [SEQ_W-1:0]     seq_number;
    logic [BYTES_W-1:0]   packet_bytes;
    logic [QLEN_W-1:0]    queue_len_a;
    logic [QLEN_W-1:0]    queue_len_b;
    logic [QLEN_W-1:0]    queue_len_c;
    logic [PATH_W-1:0]    random_path;
  } pkt_t;

  typedef struct packed {
    logic [QLEN_W-1:0]  imbalance_threshold;
    logic [BYTES_W-1:0] new_flow_min_bytes;
    logic [PATH_W-1:0]  max_path;
  } cfg_t;

  typedef struct packed {
    logic [PATH_W-1:0] chosen_path;
    logic              rerouted;
    logic              store;
  } decision_t;

  typedef struct packed {
    logic                  en;
    logic [FLOW_IDX_W-1:0] idx;
    logic [PATH_W-1:0]     path;
  } table_wr_t;

endpackage

// File: sv/flow_path_load_balancer.sv
// Top level of the flow path load balancer: stream ports, config and pipeline.
//
// Usage: one packet descriptor enters per item on the s_axis channel and one
// decision leaves per item on the m_axis channel, in order. The cfg channel
// writes imbalance_threshold (index 0), new_flow_min_bytes (index 1) and
// max_path (index 2); other indexes are dropped. cfg_ready is always high;
// write config only while no item is in flight.
//
// Pipeline: an input register holds the packet while the flow table read
// returns, then the decision is computed and loaded into the output register.
// A result shows on m_axis once the output register is free to take it from
// the input register. Throughput is one item per cycle while m_axis_tready is
// high, set by the table read and write-back in the same cycle, with a
// forwarding path for back-to-back packets of the same flow.
//
// Reset: config returns to 3 / 500 / 2, both stages empty, and all table
// valid bits clear at once so every flow reads path 0; no sweep is needed.
// Stall: when m_axis_tready is low the output register holds, the input
// register fills, and s_axis_tready drops until the receiver takes a result.
module flow_path_load_balancer (
  input  logic                               clk,
  input  logic                               rst,
  // flow_id[6:0], seq_number[38:7], packet_bytes[54:39], queue_len_a[70:55],
  // queue_len_b[86:71], queue_len_c[102:87], random_path[105:103], zero pad
  input  logic [fplb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // chosen_path[2:0], rerouted[3], zero pad
  output logic [fplb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fplb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fplb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fplb_pkg::cfg_t              cfg;
  fplb_pkg::pkt_t              in_pkt;
  fplb_pkg::pkt_t              s1_pkt;
  logic                        s1_valid;
  logic                        s1_advance;
  logic                        accept;
  logic [fplb_pkg::PATH_W-1:0] stored_path;
  fplb_pkg::decision_t         dec;
  fplb_pkg::table_wr_t         tbl_wr;
  logic [fplb_pkg::PATH_W-1:0] out_path;
  logic                        out_rerouted;
  logic                        out_valid;

  // Unpack the input item, first field in the lowest bits
  assign in_pkt.flow_id      = s_axis_tdata[6:0];
  assign in_pkt.seq_number   = s_axis_tdata[38:7];
  assign in_pkt.packet_bytes = s_axis_tdata[54:39];
  assign in_pkt.queue_len_a  = s_axis_tdata[70:55];
  assign in_pkt.queue_len_b  = s_axis_tdata[86:71];
  assign in_pkt.queue_len_c  = s_axis_tdata[102:87];
  assign in_pkt.random_path  = s_axis_tdata[105:103];

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.imbalance_threshold <= fplb_pkg::IMBALANCE_THRESHOLD_RST;
      cfg.new_flow_min_bytes  <= fplb_pkg::NEW_FLOW_MIN_BYTES_RST;
      cfg.max_path            <= fplb_pkg::MAX_PATH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fplb_pkg::REG_IMBALANCE_THRESHOLD: cfg.imbalance_threshold <= cfg_data;
        fplb_pkg::REG_NEW_FLOW_MIN_BYTES:  cfg.new_flow_min_bytes  <= cfg_data;
        fplb_pkg::REG_MAX_PATH: cfg.max_path <= cfg_data[fplb_pkg::PATH_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance the input stage when the output register is free
  assign s1_advance    = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pkt <= in_pkt;
    end
  end

  // Write back the decided path only when the item leaves the input stage
  assign tbl_wr.en   = s1_advance && dec.store;
  assign tbl_wr.idx  = s1_pkt.flow_id[fplb_pkg::FLOW_IDX_W-1:0];
  assign tbl_wr.path = dec.chosen_path;

  fplb_flow_table u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (accept),
    .rd_idx      (in_pkt.flow_id[fplb_pkg::FLOW_IDX_W-1:0]),
    .wr          (tbl_wr),
    .stored_path (stored_path)
  );

  fplb_decide u_decide (
    .pkt         (s1_pkt),
    .cfg         (cfg),
    .stored_path (stored_path),
    .dec         (dec)
  );

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_path     <= dec.chosen_path;
      out_rerouted <= dec.rerouted;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_rerouted, out_path};

endmodule

// File: sv/fplb_flow_table.sv
// Flow-to-path memory with per-entry valid bits and write-to-read forwarding.
module fplb_flow_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [fplb_pkg::FLOW_IDX_W-1:0] rd_idx,
  input  fplb_pkg::table_wr_t             wr,
  output logic [fplb_pkg::PATH_W-1:0]     stored_path
);

  logic [fplb_pkg::PATH_W-1:0]     mem [fplb_pkg::FLOW_ENTRIES];
  logic [fplb_pkg::FLOW_ENTRIES-1:0] valid;
  logic [fplb_pkg::PATH_W-1:0]     rd_data;
  logic                            rd_valid;
  logic                            fwd;
  logic [fplb_pkg::PATH_W-1:0]     fwd_path;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.path;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_idx];
      fwd_path <= wr.path;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
        // catch a write landing on the same entry at the read edge
        fwd      <= wr.en && (wr.idx == rd_idx);
      end
    end
  end

  assign stored_path = fwd      ? fwd_path :
                       rd_valid ? rd_data  : fplb_pkg::PATH_ZERO;

endmodule

// File: sv/fplb_decide.sv
// Path decision: first-segment draw, stored path reuse and imbalance reroute.
module fplb_decide (
  input  fplb_pkg::pkt_t              pkt,
  input  fplb_pkg::cfg_t              cfg,
  input  logic [fplb_pkg::PATH_W-1:0] stored_path,
  output fplb_pkg::decision_t         dec
);

  logic                          new_flow;
  logic [fplb_pkg::PATH_W-1:0]   draw;
  logic [fplb_pkg::PATH_W-1:0]   base_path;
  logic [fplb_pkg::QLEN_W-1:0]   lo_ab;
  logic [fplb_pkg::PATH_W-1:0]   lo_ab_idx;
  logic [fplb_pkg::QLEN_W-1:0]   lo_len;
  logic [fplb_pkg::PATH_W-1:0]   lo_idx;
  logic [fplb_pkg::QLEN_W-1:0]   hi_ab;
  logic [fplb_pkg::QLEN_W-1:0]   hi_len;
  logic [fplb_pkg::QLEN_W-1:0]   spread;
  logic                          move;

  always_comb begin
    new_flow  = (pkt.seq_number == fplb_pkg::FIRST_SEGMENT_SEQ) &&
                (pkt.packet_bytes > cfg.new_flow_min_bytes);
    draw      = (pkt.random_path > cfg.max_path) ? cfg.max_path : pkt.random_path;
    base_path = new_flow ? draw : stored_path;

    // lower index wins ties: replace only on strict compare
    if (pkt.queue_len_b < pkt.queue_len_a) begin
      lo_ab     = pkt.queue_len_b;
      lo_ab_idx = 3'd1;
    end else begin
      lo_ab     = pkt.queue_len_a;
      lo_ab_idx = 3'd0;
    end
    if (pkt.queue_len_c < lo_ab) begin
      lo_len = pkt.queue_len_c;
      lo_idx = 3'd2;
    end else begin
      lo_len = lo_ab;
      lo_idx = lo_ab_idx;
    end
    hi_ab  = (pkt.queue_len_b > pkt.queue_len_a) ? pkt.queue_len_b : pkt.queue_len_a;
    hi_len = (pkt.queue_len_c > hi_ab) ? pkt.queue_len_c : hi_ab;

    spread = hi_len - lo_len;
    move   = spread > cfg.imbalance_threshold;

    dec.chosen_path = move ? lo_idx : base_path;
    dec.rerouted    = move;
    dec.store       = move || new_flow;
  end

endmodule
